/* sv/sai2x_pkg.sv */
package sai2x_pkg;

  localparam logic [15:0] MASK_TWO  = 16'hF7DE;
  localparam logic [15:0] LOW_TWO   = 16'h0821;
  localparam logic [15:0] MASK_FOUR = 16'hE79C;
  localparam logic [15:0] LOW_FOUR  = 16'h1863;

  localparam int HEIGHT_LIMIT = 4096;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  localparam logic [10:0] RESET_WIDTH  = 11'd320;
  localparam logic [12:0] RESET_HEIGHT = 13'd240;

  // 4x4 neighborhood minus the far corner, named as in the 2xSaI rule
  typedef struct packed {
    logic [15:0] pi, pe, pf, pj;
    logic [15:0] pg, pa, pb, pk;
    logic [15:0] ph, pc, pd, pl;
    logic [15:0] pm, pn, po;
  } sai2x_nbhd_t;

  typedef struct packed {
    logic [9:0]  x;
    logic [11:0] y;
    logic        last;
    logic        done;
  } sai2x_tag_t;

  typedef struct packed {
    logic ad, bc, ae, bl, ac, af, be, bj, ag, co;
    logic ab, ah, gc, cm, bf, bd, ai, ch, cg, cd;
  } sai2x_eq_t;

  function automatic logic [15:0] blend2(input logic [15:0] a, input logic [15:0] b);
    blend2 = ((a & MASK_TWO) >> 1) + ((b & MASK_TWO) >> 1) + (a & b & LOW_TWO);
  endfunction

  function automatic logic [15:0] blend4(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] c, input logic [15:0] d);
    logic [15:0] hi;
    logic [17:0] lo;
    hi = ((a & MASK_FOUR) >> 2) + ((b & MASK_FOUR) >> 2) +
         ((c & MASK_FOUR) >> 2) + ((d & MASK_FOUR) >> 2);
    lo = 18'(a & LOW_FOUR) + 18'(b & LOW_FOUR) + 18'(c & LOW_FOUR) + 18'(d & LOW_FOUR);
    blend4 = hi + (lo[17:2] & LOW_FOUR);
  endfunction

endpackage

/* sv/sai_2x_upscaler_rgb565.sv */
// 2xSaI upscaler for RGB565 source pixels in raster order. Each source pixel
// yields one 2x2 output block tagged with its source column and row; borders
// are clamped by edge replication. A pixel is taken every clock unless
// in_stall is high; a pixel that releases several blocks keeps the block
// issue stage busy and may stall the input until its last block is issued,
// since that stage emits one block per clock unless the output stalls:
// the last pixel of a line releases up to 3, other pixels of the last line up
// to 3 each and the last pixel of the frame up to 9. Blocks of row r-2 come
// out while row r streams in; the pipeline from input beat to result is five
// register stages (line store read, window, neighborhood fetch, compare and
// blend, output). Three line-store banks of LINE_PIXELS pixels are all read,
// and one written, per pixel. Writing a frame register restarts the frame.
module sai_2x_upscaler_rgb565 #(
  parameter int LINE_PIXELS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_center_x,
  output logic [11:0] out_center_y,
  output logic [15:0] out_top_left,
  output logic [15:0] out_top_right,
  output logic [15:0] out_bottom_left,
  output logic [15:0] out_bottom_right,
  output logic        out_last_of_run,
  output logic        out_frame_done
);
  import sai2x_pkg::*;

  localparam int XW = $clog2(LINE_PIXELS);

  // configuration
  logic [10:0] cfg_width_r;
  logic [12:0] cfg_height_r;
  logic [31:0] w32, h32;
  logic [XW-1:0] wm1;
  logic [11:0] hm1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= RESET_WIDTH;
      cfg_height_r <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  cfg_width_r  <= cfg_data[10:0];
        CFG_HEIGHT: cfg_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w32 = 32'(cfg_width_r);
    if (w32 == 32'd0) w32 = 32'd1;
    else if (w32 > 32'(LINE_PIXELS)) w32 = 32'(LINE_PIXELS);
    h32 = 32'(cfg_height_r);
    if (h32 == 32'd0) h32 = 32'd1;
    else if (h32 > 32'(HEIGHT_LIMIT)) h32 = 32'(HEIGHT_LIMIT);
    wm1 = XW'(w32 - 32'd1);
    hm1 = 12'(h32 - 32'd1);
  end

  // pipeline enable: stage 2 onward moves when the output register is free
  logic en;
  assign en = !out_valid || !out_stall;

  // input position
  logic [XW-1:0] col_r;
  logic [11:0]   row_r;
  logic [1:0]    bank_r;
  logic          accept;
  logic          s1_take, s2_take;
  logic          s1_valid_r;

  assign s1_take  = !s1_valid_r || s2_take;
  assign in_stall = !s1_take;
  assign accept   = in_valid && s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      bank_r <= '0;
    end else if (cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT)) begin
      col_r  <= '0;
      row_r  <= '0;
      bank_r <= '0;
    end else if (accept) begin
      if (col_r == wm1) begin
        col_r <= '0;
        if (row_r == hm1) begin
          row_r  <= '0;
          bank_r <= '0;
        end else begin
          row_r  <= row_r + 12'd1;
          bank_r <= (bank_r == 2'd2) ? 2'd0 : bank_r + 2'd1;
        end
      end else begin
        col_r <= col_r + XW'(1);
      end
    end
  end

  // line store: three banks, read before write at the same column
  logic [15:0] rd_r [3];

  for (genvar g = 0; g < 3; g++) begin : g_bank
    logic [15:0] mem [LINE_PIXELS];
    always_ff @(posedge clk) begin
      if (accept) begin
        rd_r[g] <= mem[col_r];
        if (bank_r == 2'(g)) mem[col_r] <= in_pixel;
      end
    end
  end

  // stage 1: pixel and its block schedule
  logic [15:0]   s1_pix_r;
  logic [1:0]    s1_bank_r;
  logic [XW-1:0] s1_col_r, s1_xlo_r;
  logic [11:0]   s1_row_r, s1_ylo_r;
  logic [1:0]    s1_nx_r, s1_ny_r;
  logic          s1_fdone_r;
  logic [XW-1:0] xlo_nxt;
  logic [11:0]   ylo_nxt;
  logic [1:0]    nx_nxt, ny_nxt;

  always_comb begin
    if (col_r == wm1) begin
      xlo_nxt = (col_r >= XW'(2)) ? col_r - XW'(2) : '0;
      nx_nxt  = (col_r >= XW'(2)) ? 2'd3 : 2'(col_r) + 2'd1;
    end else if (col_r >= XW'(2)) begin
      xlo_nxt = col_r - XW'(2);
      nx_nxt  = 2'd1;
    end else begin
      xlo_nxt = '0;
      nx_nxt  = 2'd0;
    end
    if (row_r == hm1) begin
      ylo_nxt = (row_r >= 12'd2) ? row_r - 12'd2 : '0;
      ny_nxt  = (row_r >= 12'd2) ? 2'd3 : 2'(row_r) + 2'd1;
    end else if (row_r >= 12'd2) begin
      ylo_nxt = row_r - 12'd2;
      ny_nxt  = 2'd1;
    end else begin
      ylo_nxt = '0;
      ny_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else if (s1_take) s1_valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r   <= in_pixel;
      s1_bank_r  <= bank_r;
      s1_col_r   <= col_r;
      s1_row_r   <= row_r;
      s1_xlo_r   <= xlo_nxt;
      s1_ylo_r   <= ylo_nxt;
      s1_nx_r    <= nx_nxt;
      s1_ny_r    <= ny_nxt;
      s1_fdone_r <= (col_r == wm1) && (row_r == hm1);
    end
  end

  // stage 2: window and block issue
  logic [15:0]   win_r [4][4];
  logic          s2_valid_r;
  logic [XW-1:0] s2_col_r, s2_xlo_r;
  logic [11:0]   s2_row_r, s2_ylo_r;
  logic [1:0]    s2_nx_r, s2_ny_r, s2_xi_r, s2_yi_r;
  logic          s2_fdone_r;
  logic          s2_issue, s2_final, s2_done;
  logic [15:0]   newcol [4];

  assign s2_issue = s2_valid_r && (s2_nx_r != 2'd0) && (s2_ny_r != 2'd0);
  assign s2_final = (s2_xi_r == s2_nx_r - 2'd1) && (s2_yi_r == s2_ny_r - 2'd1);
  assign s2_done  = !s2_issue || s2_final;
  assign s2_take  = en && s2_done;

  always_comb begin
    // oldest row lives in the bank being overwritten
    case (s1_bank_r)
      2'd0:    begin newcol[0] = rd_r[0]; newcol[1] = rd_r[1]; newcol[2] = rd_r[2]; end
      2'd1:    begin newcol[0] = rd_r[1]; newcol[1] = rd_r[2]; newcol[2] = rd_r[0]; end
      default: begin newcol[0] = rd_r[2]; newcol[1] = rd_r[0]; newcol[2] = rd_r[1]; end
    endcase
    newcol[3] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s2_xi_r    <= '0;
      s2_yi_r    <= '0;
    end else if (s2_take) begin
      s2_valid_r <= s1_valid_r;
      s2_xi_r    <= '0;
      s2_yi_r    <= '0;
    end else if (en && s2_issue) begin
      if (s2_xi_r == s2_nx_r - 2'd1) begin
        s2_xi_r <= '0;
        s2_yi_r <= s2_yi_r + 2'd1;
      end else begin
        s2_xi_r <= s2_xi_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take && s1_valid_r) begin
      s2_col_r   <= s1_col_r;
      s2_row_r   <= s1_row_r;
      s2_xlo_r   <= s1_xlo_r;
      s2_ylo_r   <= s1_ylo_r;
      s2_nx_r    <= s1_nx_r;
      s2_ny_r    <= s1_ny_r;
      s2_fdone_r <= s1_fdone_r;
      for (int i = 0; i < 4; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
        win_r[i][2] <= win_r[i][3];
        win_r[i][3] <= newcol[i];
      end
    end
  end

  // clamp a neighbor coordinate into the frame, keep its window slot bits
  function automatic logic [1:0] clamp2(input logic [12:0] v, input logic [1:0] d,
                                        input logic [12:0] vmax);
    logic [13:0] s;
    if (d == 2'd0) s = (v == 13'd0) ? 14'd0 : {1'b0, v} - 14'd1;
    else s = {1'b0, v} + 14'(d) - 14'd1;
    if (s > {1'b0, vmax}) s = {1'b0, vmax};
    clamp2 = s[1:0];
  endfunction

  logic [XW-1:0] blk_x;
  logic [11:0]   blk_y;
  logic [1:0]    ri [4];
  logic [1:0]    cj [4];
  logic [15:0]   pix [4][4];
  sai2x_nbhd_t   nb;
  sai2x_tag_t    tag;

  always_comb begin
    blk_x = s2_xlo_r + XW'(s2_xi_r);
    blk_y = s2_ylo_r + 12'(s2_yi_r);
    for (int k = 0; k < 4; k++) begin
      ri[k] = clamp2(13'(blk_y), 2'(k), 13'(hm1)) - s2_row_r[1:0] + 2'd3;
      cj[k] = clamp2(13'(blk_x), 2'(k), 13'(wm1)) - 2'(s2_col_r) + 2'd3;
    end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        pix[i][j] = win_r[ri[i]][cj[j]];
    nb.pi = pix[0][0]; nb.pe = pix[0][1]; nb.pf = pix[0][2]; nb.pj = pix[0][3];
    nb.pg = pix[1][0]; nb.pa = pix[1][1]; nb.pb = pix[1][2]; nb.pk = pix[1][3];
    nb.ph = pix[2][0]; nb.pc = pix[2][1]; nb.pd = pix[2][2]; nb.pl = pix[2][3];
    nb.pm = pix[3][0]; nb.pn = pix[3][1]; nb.po = pix[3][2];
    tag.x    = 10'(blk_x);
    tag.y    = blk_y;
    tag.last = s2_final;
    tag.done = s2_final && s2_fdone_r;
  end

  // stage 3: neighborhood
  logic        s3_valid_r;
  sai2x_nbhd_t s3_nb_r;
  sai2x_tag_t  s3_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_valid_r <= 1'b0;
    else if (en) s3_valid_r <= s2_issue;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_nb_r  <= nb;
      s3_tag_r <= tag;
    end
  end

  // stage 4: compares, votes and blends
  sai2x_eq_t eq;
  logic [2:0] vp, vm;

  always_comb begin
    eq.ad = s3_nb_r.pa == s3_nb_r.pd; eq.bc = s3_nb_r.pb == s3_nb_r.pc;
    eq.ae = s3_nb_r.pa == s3_nb_r.pe; eq.bl = s3_nb_r.pb == s3_nb_r.pl;
    eq.ac = s3_nb_r.pa == s3_nb_r.pc; eq.af = s3_nb_r.pa == s3_nb_r.pf;
    eq.be = s3_nb_r.pb == s3_nb_r.pe; eq.bj = s3_nb_r.pb == s3_nb_r.pj;
    eq.ag = s3_nb_r.pa == s3_nb_r.pg; eq.co = s3_nb_r.pc == s3_nb_r.po;
    eq.ab = s3_nb_r.pa == s3_nb_r.pb; eq.ah = s3_nb_r.pa == s3_nb_r.ph;
    eq.gc = s3_nb_r.pg == s3_nb_r.pc; eq.cm = s3_nb_r.pc == s3_nb_r.pm;
    eq.bf = s3_nb_r.pb == s3_nb_r.pf; eq.bd = s3_nb_r.pb == s3_nb_r.pd;
    eq.ai = s3_nb_r.pa == s3_nb_r.pi; eq.ch = s3_nb_r.pc == s3_nb_r.ph;
    eq.cg = s3_nb_r.pc == s3_nb_r.pg; eq.cd = s3_nb_r.pc == s3_nb_r.pd;
    // vote sum split into positive and negative counts
    vp = 3'((s3_nb_r.pa != s3_nb_r.pg) || (s3_nb_r.pa != s3_nb_r.pe))
       + 3'((s3_nb_r.pb != s3_nb_r.pk) || (s3_nb_r.pb != s3_nb_r.pf))
       + 3'((s3_nb_r.pb != s3_nb_r.ph) || (s3_nb_r.pb != s3_nb_r.pn))
       + 3'((s3_nb_r.pa != s3_nb_r.pl) || (s3_nb_r.pa != s3_nb_r.po));
    vm = 3'((s3_nb_r.pb != s3_nb_r.pg) || (s3_nb_r.pb != s3_nb_r.pe))
       + 3'((s3_nb_r.pa != s3_nb_r.pk) || (s3_nb_r.pa != s3_nb_r.pf))
       + 3'((s3_nb_r.pa != s3_nb_r.ph) || (s3_nb_r.pa != s3_nb_r.pn))
       + 3'((s3_nb_r.pb != s3_nb_r.pl) || (s3_nb_r.pb != s3_nb_r.po));
  end

  logic        s4_valid_r;
  sai2x_tag_t  s4_tag_r;
  sai2x_eq_t   s4_eq_r;
  logic [15:0] s4_a_r, s4_b_r, s4_c_r, s4_b2ab_r, s4_b2ac_r, s4_b4_r;
  logic        s4_gt_r, s4_lt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_valid_r <= 1'b0;
    else if (en) s4_valid_r <= s3_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_tag_r  <= s3_tag_r;
      s4_eq_r   <= eq;
      s4_a_r    <= s3_nb_r.pa;
      s4_b_r    <= s3_nb_r.pb;
      s4_c_r    <= s3_nb_r.pc;
      s4_b2ab_r <= blend2(s3_nb_r.pa, s3_nb_r.pb);
      s4_b2ac_r <= blend2(s3_nb_r.pa, s3_nb_r.pc);
      s4_b4_r   <= blend4(s3_nb_r.pa, s3_nb_r.pb, s3_nb_r.pc, s3_nb_r.pd);
      s4_gt_r   <= vp > vm;
      s4_lt_r   <= vp < vm;
    end
  end

  // edge rule selection
  logic [15:0] tr_nxt, bl_nxt, br_nxt;
  sai2x_eq_t q;

  always_comb begin
    q = s4_eq_r;
    if (q.ad && !q.bc) begin
      tr_nxt = ((q.ae && q.bl) || (q.ac && q.af && !q.be && q.bj)) ? s4_a_r : s4_b2ab_r;
      bl_nxt = ((q.ag && q.co) || (q.ab && q.ah && !q.gc && q.cm)) ? s4_a_r : s4_b2ac_r;
      br_nxt = s4_a_r;
    end else if (q.bc && !q.ad) begin
      tr_nxt = ((q.bf && q.ah) || (q.be && q.bd && !q.af && q.ai)) ? s4_b_r : s4_b2ab_r;
      bl_nxt = ((q.ch && q.af) || (q.cg && q.cd && !q.ah && q.ai)) ? s4_c_r : s4_b2ac_r;
      br_nxt = s4_b_r;
    end else if (q.ad && q.bc) begin
      if (q.ab) begin
        tr_nxt = s4_a_r;
        bl_nxt = s4_a_r;
        br_nxt = s4_a_r;
      end else begin
        tr_nxt = s4_b2ab_r;
        bl_nxt = s4_b2ac_r;
        br_nxt = s4_gt_r ? s4_a_r : (s4_lt_r ? s4_b_r : s4_b4_r);
      end
    end else begin
      br_nxt = s4_b4_r;
      if (q.ac && q.af && !q.be && q.bj) tr_nxt = s4_a_r;
      else if (q.be && q.bd && !q.af && q.ai) tr_nxt = s4_b_r;
      else tr_nxt = s4_b2ab_r;
      if (q.ab && q.ah && !q.gc && q.cm) bl_nxt = s4_a_r;
      else if (q.cg && q.cd && !q.ah && q.ai) bl_nxt = s4_c_r;
      else bl_nxt = s4_b2ac_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= s4_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_center_x     <= s4_tag_r.x;
      out_center_y     <= s4_tag_r.y;
      out_top_left     <= s4_a_r;
      out_top_right    <= tr_nxt;
      out_bottom_left  <= bl_nxt;
      out_bottom_right <= br_nxt;
      out_last_of_run  <= s4_tag_r.last;
      out_frame_done   <= s4_tag_r.done;
    end
  end

endmodule

/* sv/sai2x_checker.sv */
module sai2x_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [9:0]  out_center_x,
  input logic [11:0] out_center_y,
  input logic [15:0] out_top_right,
  input logic        out_last_of_run,
  input logic        out_frame_done
);

  // a stalled beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped under stall");

  // a stalled beat keeps its position and top-right pixel
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_center_x) && $stable(out_center_y)
                               && $stable(out_top_right))
    else $error("result beat changed under stall");

  // the frame ends on the last block of a run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_last_of_run)
    else $error("frame end not on last block of run");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sai_2x_upscaler_rgb565 sai2x_checker u_sai2x_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_center_x    (out_center_x),
  .out_center_y    (out_center_y),
  .out_top_right   (out_top_right),
  .out_last_of_run (out_last_of_run),
  .out_frame_done  (out_frame_done)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import sai2x_pkg::*;

  typedef struct {
    logic [9:0]  x;
    logic [11:0] y;
    logic [15:0] tl, tr, bl, br;
    logic        last, done;
  } block_t;

  typedef struct {
    logic [15:0] pixel;
    logic        fixed;
    logic [15:0] fixed_val;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_pixel = '0;
  logic        in_fixed = 1'b0;
  logic [15:0] in_fixed_val = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [9:0]  out_center_x;
  logic [11:0] out_center_y;
  logic [15:0] out_top_left, out_top_right, out_bottom_left, out_bottom_right;
  logic        out_last_of_run, out_frame_done;

  sai_2x_upscaler_rgb565 u_top (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("DONE: errors detected");
    $finish;
  end

  // predictor state
  logic [15:0] line_mem [0:3*1024-1];
  logic [15:0] win [0:15];
  int          col_pos, row_pos;
  logic [10:0] width_reg;
  logic [12:0] height_reg;

  block_t blocks_due [$];
  int     errors = 0;
  int     sent = 0;
  bit     hold_req = 0;
  bit     quiet = 0;

  function automatic logic [15:0] avg2(logic [15:0] a, logic [15:0] b);
    logic [31:0] s;
    s = ((a & MASK_TWO) >> 1) + ((b & MASK_TWO) >> 1) + (a & b & LOW_TWO);
    return s[15:0];
  endfunction

  function automatic logic [15:0] avg4(logic [15:0] a, logic [15:0] b,
                                       logic [15:0] c, logic [15:0] d);
    logic [31:0] hi, lo;
    hi = 32'((a & MASK_FOUR) >> 2) + 32'((b & MASK_FOUR) >> 2) +
         32'((c & MASK_FOUR) >> 2) + 32'((d & MASK_FOUR) >> 2);
    lo = ((32'(a & LOW_FOUR) + 32'(b & LOW_FOUR) + 32'(c & LOW_FOUR) +
           32'(d & LOW_FOUR)) >> 2) & 32'(LOW_FOUR);
    return 16'(hi + lo);
  endfunction

  function automatic int ballot(logic [15:0] a, logic [15:0] b, logic [15:0] p,
                                logic [15:0] q);
    return int'(a != p || a != q) - int'(b != p || b != q);
  endfunction

  function automatic logic [15:0] nb(int col, int row, int c, int r, int w, int h);
    int i, j;
    if (col < 0) col = 0;
    if (col > w - 1) col = w - 1;
    if (row < 0) row = 0;
    if (row > h - 1) row = h - 1;
    j = (col - c + 3) & 3;
    i = (row - r + 3) & 3;
    return win[i * 4 + j];
  endfunction

  function automatic block_t upscale_block(int x, int y, int c, int r, int w, int h);
    logic [15:0] pi, pe, pf, pj, pg, pa, pb, pk, ph, pc, pd, pl, pm, pn, po;
    block_t blk;
    int s;
    pi = nb(x-1, y-1, c, r, w, h); pe = nb(x, y-1, c, r, w, h);
    pf = nb(x+1, y-1, c, r, w, h); pj = nb(x+2, y-1, c, r, w, h);
    pg = nb(x-1, y, c, r, w, h);   pa = nb(x, y, c, r, w, h);
    pb = nb(x+1, y, c, r, w, h);   pk = nb(x+2, y, c, r, w, h);
    ph = nb(x-1, y+1, c, r, w, h); pc = nb(x, y+1, c, r, w, h);
    pd = nb(x+1, y+1, c, r, w, h); pl = nb(x+2, y+1, c, r, w, h);
    pm = nb(x-1, y+2, c, r, w, h); pn = nb(x, y+2, c, r, w, h);
    po = nb(x+1, y+2, c, r, w, h);
    if (pa == pd && pb != pc) begin
      blk.tr = ((pa == pe && pb == pl) || (pa == pc && pa == pf && pb != pe && pb == pj))
               ? pa : avg2(pa, pb);
      blk.bl = ((pa == pg && pc == po) || (pa == pb && pa == ph && pg != pc && pc == pm))
               ? pa : avg2(pa, pc);
      blk.br = pa;
    end else if (pb == pc && pa != pd) begin
      blk.tr = ((pb == pf && pa == ph) || (pb == pe && pb == pd && pa != pf && pa == pi))
               ? pb : avg2(pa, pb);
      blk.bl = ((pc == ph && pa == pf) || (pc == pg && pc == pd && pa != ph && pa == pi))
               ? pc : avg2(pa, pc);
      blk.br = pb;
    end else if (pa == pd && pb == pc) begin
      if (pa == pb) begin
        blk.tr = pa; blk.bl = pa; blk.br = pa;
      end else begin
        s = ballot(pa, pb, pg, pe) + ballot(pb, pa, pk, pf) + ballot(pb, pa, ph, pn) +
            ballot(pa, pb, pl, po);
        blk.tr = avg2(pa, pb);
        blk.bl = avg2(pa, pc);
        blk.br = s > 0 ? pa : (s < 0 ? pb : avg4(pa, pb, pc, pd));
      end
    end else begin
      blk.br = avg4(pa, pb, pc, pd);
      if (pa == pc && pa == pf && pb != pe && pb == pj) blk.tr = pa;
      else if (pb == pe && pb == pd && pa != pf && pa == pi) blk.tr = pb;
      else blk.tr = avg2(pa, pb);
      if (pa == pb && pa == ph && pg != pc && pc == pm) blk.bl = pa;
      else if (pc == pg && pc == pd && pa != ph && pa == pi) blk.bl = pc;
      else blk.bl = avg2(pa, pc);
    end
    blk.x = 10'(x);
    blk.y = 12'(y);
    blk.tl = pa;
    blk.last = 1'b0;
    blk.done = 1'b0;
    return blk;
  endfunction

  task automatic predict_pixel(logic [15:0] px, logic fixed, logic [15:0] fixed_val);
    int w, h, c, r, xlo, xhi, ylo, yhi;
    logic [15:0] colv [4];
    block_t run [$];
    block_t blk;
    w = (width_reg == 0) ? 1 : (width_reg > 1024 ? 1024 : int'(width_reg));
    h = (height_reg == 0) ? 1 : (height_reg > HEIGHT_LIMIT ? HEIGHT_LIMIT : int'(height_reg));
    c = col_pos;
    r = row_pos;
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    colv[0] = r >= 3 ? line_mem[(r % 3) * 1024 + c] : 16'h0;
    colv[1] = r >= 2 ? line_mem[((r + 1) % 3) * 1024 + c] : 16'h0;
    colv[2] = r >= 1 ? line_mem[((r + 2) % 3) * 1024 + c] : 16'h0;
    colv[3] = px;
    for (int i = 0; i < 4; i++) begin
      win[i*4+0] = win[i*4+1];
      win[i*4+1] = win[i*4+2];
      win[i*4+2] = win[i*4+3];
      win[i*4+3] = colv[i];
    end
    line_mem[(r % 3) * 1024 + c] = px;
    if (r == h - 1) begin
      ylo = r >= 2 ? r - 2 : 0; yhi = r;
    end else if (r >= 2) begin
      ylo = r - 2; yhi = r - 2;
    end else begin
      ylo = 1; yhi = 0;
    end
    if (c == w - 1) begin
      xlo = c >= 2 ? c - 2 : 0; xhi = c;
    end else if (c >= 2) begin
      xlo = c - 2; xhi = c - 2;
    end else begin
      xlo = 1; xhi = 0;
    end
    for (int y = ylo; y <= yhi; y++)
      for (int x = xlo; x <= xhi; x++) begin
        blk = upscale_block(x, y, c, r, w, h);
        if (fixed) begin
          blk.tl = fixed_val; blk.tr = fixed_val; blk.bl = fixed_val; blk.br = fixed_val;
        end
        run.push_back(blk);
      end
    if (run.size() > 0) begin
      run[run.size()-1].last = 1'b1;
      run[run.size()-1].done = (r == h - 1 && c == w - 1);
    end
    foreach (run[k]) blocks_due.push_back(run[k]);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // input and config side of the predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) begin
          width_reg = cfg_data[10:0];
          col_pos = 0; row_pos = 0;
        end else if (cfg_index == CFG_HEIGHT) begin
          height_reg = cfg_data;
          col_pos = 0; row_pos = 0;
        end
      end
      if (in_valid && !in_stall) predict_pixel(in_pixel, in_fixed, in_fixed_val);
    end
  end

  // result side
  always @(posedge clk) begin
    block_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (blocks_due.size() == 0) begin
        $error("unexpected block at x=%0d y=%0d", out_center_x, out_center_y);
        errors++;
      end else begin
        e = blocks_due.pop_front();
        check_field("center_x", 16'(e.x), 16'(out_center_x));
        check_field("center_y", 16'(e.y), 16'(out_center_y));
        check_field("top_left", e.tl, out_top_left);
        check_field("top_right", e.tr, out_top_right);
        check_field("bottom_left", e.bl, out_bottom_left);
        check_field("bottom_right", e.br, out_bottom_right);
        check_field("last_of_run", 16'(e.last), 16'(out_last_of_run));
        check_field("frame_done", 16'(e.done), 16'(out_frame_done));
      end
    end
  end

  function automatic int gap_len();
    int p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver back-pressure
  initial begin
    int run_left;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
      end else if (quiet || $urandom_range(0, 1) == 0) begin
        out_stall <= 1'b0;
        run_left = $urandom_range(0, 30);
      end else begin
        out_stall <= 1'b1;
        run_left = gap_len();
      end
    end
  end

  task automatic send_pixel(logic [15:0] px, logic fixed = 1'b0, logic [15:0] fv = '0);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    in_fixed <= fixed;
    in_fixed_val <= fv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // stop offering beats, wait for every block, then let the pipe empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (blocks_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  logic [15:0] palette [4];
  int          npal;

  function automatic logic [15:0] rand_pixel();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return palette[$urandom_range(0, npal - 1)];
  endfunction

  task automatic stream(int npx);
    for (int i = 0; i < npx; i++) send_pixel(rand_pixel());
    drain();
  endtask

  task automatic new_palette();
    npal = $urandom_range(2, 4);
    foreach (palette[i]) palette[i] = 16'($urandom);
  endtask

  dir_row_t dir_rows [24];

  initial begin
    int w, h, npx, phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 4x6 frame: top four lines all white, so blocks of rows 0..1 stay white
    foreach (dir_rows[i]) begin
      dir_rows[i].pixel = 16'hFFFF;
      dir_rows[i].fixed = (i < 16);
      dir_rows[i].fixed_val = 16'hFFFF;
    end
    dir_rows[16].pixel = 16'h0000; dir_rows[17].pixel = 16'hFFFF;
    dir_rows[18].pixel = MASK_TWO; dir_rows[19].pixel = LOW_TWO;
    dir_rows[20].pixel = MASK_FOUR; dir_rows[21].pixel = LOW_FOUR;
    dir_rows[22].pixel = 16'h0000; dir_rows[23].pixel = 16'hF800;
    cfg_write(CFG_WIDTH, 13'd4);
    cfg_write(CFG_HEIGHT, 13'd6);
    foreach (dir_rows[i]) send_pixel(dir_rows[i].pixel, dir_rows[i].fixed,
                                     dir_rows[i].fixed_val);
    drain();

    // register extremes and out-of-range values
    new_palette();
    cfg_write(CFG_WIDTH, 13'd1024);
    cfg_write(CFG_HEIGHT, 13'd4);
    stream(40);
    cfg_write(CFG_WIDTH, 13'd4);
    cfg_write(CFG_HEIGHT, 13'd4096);
    stream(40);
    cfg_write(CFG_WIDTH, 13'd0);
    cfg_write(CFG_HEIGHT, 13'd4);
    stream(12);
    cfg_write(CFG_WIDTH, 13'd2047);
    cfg_write(CFG_HEIGHT, 13'd5);
    stream(30);
    cfg_write(CFG_WIDTH, 13'd5);
    cfg_write(CFG_HEIGHT, 13'd0);
    stream(15);
    // unused index: frame position must carry on
    cfg_write(2'd3, 13'($urandom));
    stream(10);
    cfg_write(CFG_HEIGHT, 13'd8191);
    cfg_write(CFG_WIDTH, 13'd7);
    stream(30);

    sent = 0;
    phase = 0;
    while (sent < 180) begin
      new_palette();
      w = ($urandom_range(0, 4) != 0) ? $urandom_range(4, 9) : $urandom_range(10, 40);
      h = $urandom_range(4, 7);
      npx = w * h * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) npx = $urandom_range(1, w * h);
      if (npx > 180 - sent) npx = 180 - sent;
      if ($urandom_range(0, 1) == 0) begin
        cfg_write(CFG_WIDTH, 13'(w));
        cfg_write(CFG_HEIGHT, 13'(h));
      end else begin
        cfg_write(CFG_HEIGHT, 13'(h));
        cfg_write(CFG_WIDTH, 13'(w));
      end
      quiet = ($urandom_range(0, 3) == 0);
      if (phase == 0) begin
        quiet = 1;
        hold_req = 1;
      end
      stream(npx);
      quiet = 0;
      phase++;
    end

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
